/* sv/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_STEP  = 1'b1
  } req_type_t;

  // Classification of one queued item
  typedef struct packed {
    logic is_start;
    logic dir_x_neg;
    logic dir_y_neg;
  } lr_flags_t;

  localparam int FLAGS_W = $bits(lr_flags_t);

endpackage

/* sv/lr_front.sv */
// ----------------------------------------------------------------------------
// lr_front
// Classifies an incoming item and works out direction and span for a start.
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x_in,
  input  logic [COORD_BITS-1:0] end_y_in,
  output lr_flags_t             flags,
  output logic [COORD_BITS-1:0] span_x,
  output logic [COORD_BITS-1:0] span_y
);

  always_comb begin
    flags.is_start  = (req_type_t'(req_type) == REQ_START);
    flags.dir_x_neg = end_x_in < start_x;
    flags.dir_y_neg = end_y_in < start_y;
    span_x = flags.dir_x_neg ? start_x - end_x_in : end_x_in - start_x;
    span_y = flags.dir_y_neg ? start_y - end_y_in : end_y_in - start_y;
  end

endmodule

/* sv/lr_queue.sv */
// ----------------------------------------------------------------------------
// lr_queue
// Two-entry FIFO between the front and the back part.
// ----------------------------------------------------------------------------
module lr_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  // two entries: one-bit pointers, count 0..2
  logic [WIDTH-1:0] entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/lr_back.sv */
// ----------------------------------------------------------------------------
// lr_back
// Holds the line state, runs one Bresenham step per step item, output register.
// ----------------------------------------------------------------------------
module lr_back
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  lr_flags_t             q_flags,
  input  logic [COORD_BITS-1:0] q_start_x,
  input  logic [COORD_BITS-1:0] q_start_y,
  input  logic [COORD_BITS-1:0] q_end_x,
  input  logic [COORD_BITS-1:0] q_end_y,
  input  logic [COORD_BITS-1:0] q_span_x,
  input  logic [COORD_BITS-1:0] q_span_y,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);

  localparam int C = COORD_BITS;
  localparam logic [C-1:0] ONE = {{(C-1){1'b0}}, 1'b1};

  logic [C-1:0]        cur_x, cur_y, goal_x, goal_y, span_x, span_y;
  logic                dir_x_neg, dir_y_neg;
  logic signed [C+1:0] error_term;
  logic                active;

  logic signed [C+2:0] e2, spx_w, spy_w;
  logic signed [C+1:0] spx_e, spy_e, err_next;
  logic                step_x, step_y;
  logic [C-1:0]        x_next, y_next;
  logic                out_free, emit, fin;

  always_comb begin
    e2     = {error_term, 1'b0};
    spx_w  = $signed({3'b000, span_x});
    spy_w  = $signed({3'b000, span_y});
    spx_e  = $signed({2'b00, span_x});
    spy_e  = $signed({2'b00, span_y});
    step_x = e2 > -spy_w;
    step_y = e2 < spx_w;
    err_next = error_term;
    x_next   = cur_x;
    y_next   = cur_y;
    if (step_x) begin
      err_next = err_next - spy_e;
      x_next   = dir_x_neg ? cur_x - ONE : cur_x + ONE;
    end
    if (step_y) begin
      err_next = err_next + spx_e;
      y_next   = dir_y_neg ? cur_y - ONE : cur_y + ONE;
    end
  end

  // a step with no line in progress is dropped without needing the output
  assign out_free = !out_valid || out_ready;
  assign q_pop    = q_valid && (out_free || (!q_flags.is_start && !active));
  assign emit     = q_pop && (q_flags.is_start || active);
  assign fin      = q_flags.is_start ? (q_start_x == q_end_x) && (q_start_y == q_end_y)
                                     : (x_next == goal_x) && (y_next == goal_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        active    <= !fin;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit && q_flags.is_start) begin
      cur_x      <= q_start_x;
      cur_y      <= q_start_y;
      goal_x     <= q_end_x;
      goal_y     <= q_end_y;
      span_x     <= q_span_x;
      span_y     <= q_span_y;
      dir_x_neg  <= q_flags.dir_x_neg;
      dir_y_neg  <= q_flags.dir_y_neg;
      error_term <= $signed({2'b00, q_span_x}) - $signed({2'b00, q_span_y});
      pixel_x    <= q_start_x;
      pixel_y    <= q_start_y;
      last       <= fin;
    end else if (emit) begin
      cur_x      <= x_next;
      cur_y      <= y_next;
      error_term <= err_next;
      pixel_x    <= x_next;
      pixel_y    <= y_next;
      last       <= fin;
    end
  end

endmodule

/* sv/line_rasterizer_core.sv */
// An accepted item is held in a queue entry, and its pixel then in the output
// register, before the result is handed out.
// Throughput: one item per cycle sustained while out_ready does not stall the
// output; one Bresenham step (both error compares and adds) runs per cycle in the back part.
// A two-entry queue between front and back absorbs output stalls.
// Reset (synchronous) empties the queue, drops any line and clears out_valid.
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Integer Bresenham line rasterizer, one pixel per start item and per step of a line in progress.
// ----------------------------------------------------------------------------
module line_rasterizer_core
  import lr_pkg::*;
#(
  parameter int COORD_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x_in,
  input  logic [COORD_BITS-1:0] end_y_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pixel_x,
  output logic [COORD_BITS-1:0] pixel_y,
  output logic                  last
);

  localparam int C  = COORD_BITS;
  localparam int QW = FLAGS_W + 6 * C;

  lr_flags_t    f_flags, q_flags;
  logic [C-1:0] f_span_x, f_span_y;
  logic [C-1:0] q_start_x, q_start_y, q_end_x, q_end_y, q_span_x, q_span_y;
  logic [QW-1:0] q_in, q_out;
  logic         q_valid, q_pop;

  lr_front #(.COORD_BITS(C)) u_front (
    .req_type (req_type),
    .start_x  (start_x),
    .start_y  (start_y),
    .end_x_in (end_x_in),
    .end_y_in (end_y_in),
    .flags    (f_flags),
    .span_x   (f_span_x),
    .span_y   (f_span_y)
  );

  assign q_in = {f_flags, start_x, start_y, end_x_in, end_y_in, f_span_x, f_span_y};

  lr_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (q_in),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  assign {q_flags, q_start_x, q_start_y, q_end_x, q_end_y, q_span_x, q_span_y} = q_out;

  lr_back #(.COORD_BITS(C)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_flags   (q_flags),
    .q_start_x (q_start_x),
    .q_start_y (q_start_y),
    .q_end_x   (q_end_x),
    .q_end_y   (q_end_y),
    .q_span_x  (q_span_x),
    .q_span_y  (q_span_y),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .pixel_x   (pixel_x),
    .pixel_y   (pixel_y),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_pop_has_item: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("queue full but shows no item");

  a_start_emits: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_flags.is_start) |=> out_valid)
    else $error("start item gave no pixel");

  a_pop_frees_out: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_flags.is_start) |-> (!out_valid || out_ready))
    else $error("start item popped over a held result");
`endif

endmodule

/* sim/tb_line_rasterizer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_line_rasterizer_core
// Self-checking bench for the Bresenham line rasterizer. A built-in line
// walker predicts each pixel from the accepted requests. The output side
// compares every pixel against the oldest predicted one. Both handshakes
// idle at random. Directed lines cover the corners and the special cases,
// then random lines follow in every direction.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_core;
  import lr_pkg::*;

  localparam int CB            = 10;
  localparam int CMAX          = (1 << CB) - 1;
  localparam int RANDOM_ITEMS  = 925;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          fin;
  } pixel_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          in_valid  = 1'b0;
  logic          in_ready;
  req_type_t     req_type  = REQ_START;
  logic [CB-1:0] start_x   = '0;
  logic [CB-1:0] start_y   = '0;
  logic [CB-1:0] end_x_in  = '0;
  logic [CB-1:0] end_y_in  = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  logic [CB-1:0] pixel_x;
  logic [CB-1:0] pixel_y;
  logic          last;

  // Predicted line walker state
  logic [CB-1:0] walk_x, walk_y, goal_x, goal_y, span_x, span_y;
  logic          neg_x, neg_y, line_busy;
  int            walk_err;

  pixel_t pixel_q[$];
  int     items_sent  = 0;
  int     fail_count  = 0;
  int     cycle_count = 0;
  bit     tx_burst    = 1'b0;
  bit     rx_burst    = 1'b0;

  line_rasterizer_core #(.COORD_BITS(CB)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type),
    .start_x(start_x), .start_y(start_y),
    .end_x_in(end_x_in), .end_y_in(end_y_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .last(last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d pixels still due", $time, pixel_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Walk the line one request at a time and queue the pixel it yields.
  task automatic rasterize_item(input req_type_t kind, input logic [CB-1:0] sx,
                                input logic [CB-1:0] sy, input logic [CB-1:0] ex,
                                input logic [CB-1:0] ey);
    int     e2;
    int     nerr;
    pixel_t p;
    if (kind == REQ_START) begin
      walk_x   = sx;
      walk_y   = sy;
      goal_x   = ex;
      goal_y   = ey;
      neg_x    = ex < sx;
      neg_y    = ey < sy;
      span_x   = neg_x ? sx - ex : ex - sx;
      span_y   = neg_y ? sy - ey : ey - sy;
      walk_err = int'(span_x) - int'(span_y);
    end else begin
      if (!line_busy) return;
      e2   = walk_err * 2;
      nerr = walk_err;
      if (e2 > -int'(span_y)) begin
        nerr   = nerr - int'(span_y);
        walk_x = neg_x ? walk_x - 1'b1 : walk_x + 1'b1;
      end
      if (e2 < int'(span_x)) begin
        nerr   = nerr + int'(span_x);
        walk_y = neg_y ? walk_y - 1'b1 : walk_y + 1'b1;
      end
      walk_err = nerr;
    end
    p.x       = walk_x;
    p.y       = walk_y;
    p.fin     = (walk_x == goal_x) && (walk_y == goal_y);
    line_busy = !p.fin;
    pixel_q.push_back(p);
  endtask

  // Predict on input handshakes first, then check output handshakes.
  always @(posedge clk) begin
    pixel_t want;
    if (!rst) begin
      if (in_valid && in_ready)
        rasterize_item(req_type, start_x, start_y, end_x_in, end_y_in);
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected pixel, exp none, got x=%0d y=%0d last=%0b", $time,
                   pixel_x, pixel_y, last);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x !== want.x || pixel_y !== want.y || last !== want.fin) begin
            fail_count++;
            $display("%0t: pixel mismatch exp x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                     $time, want.x, want.y, want.fin, pixel_x, pixel_y, last);
          end
        end
      end
    end
  end

  // Output side: random stall before taking each pixel.
  initial begin
    int stall;
    repeat (12) @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_item(input req_type_t kind, input logic [CB-1:0] sx,
                           input logic [CB-1:0] sy, input logic [CB-1:0] ex,
                           input logic [CB-1:0] ey);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    start_x  <= sx;
    start_y  <= sy;
    end_x_in <= ex;
    end_y_in <= ey;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Step request; coordinate fields carry junk that must be ignored.
  task automatic send_step();
    send_item(REQ_STEP, CB'($urandom), CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  function automatic logic [CB-1:0] near_coord(input int c, input int reach);
    int lo;
    int hi;
    lo = (c - reach < 0) ? 0 : c - reach;
    hi = (c + reach > CMAX) ? CMAX : c + reach;
    return CB'($urandom_range(hi, lo));
  endfunction

  function automatic logic [CB-1:0] edge_coord();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return CB'(1);
      2:       return CB'(CMAX - 1);
      3:       return CB'(CMAX);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic test_step_without_line();
    send_step();
  endtask

  task automatic test_zero_length_lines();
    send_item(REQ_START, '0, '0, '0, '0);
    send_item(REQ_START, CB'(CMAX), CB'(CMAX), CB'(CMAX), CB'(CMAX));
    send_step();
  endtask

  // Corner-to-corner lines; the second start drops the first mid-walk.
  task automatic test_extreme_endpoints();
    send_item(REQ_START, '0, '0, CB'(CMAX), CB'(CMAX));
    repeat (2) send_step();
    send_item(REQ_START, CB'(CMAX), '0, '0, CB'(CMAX));
    repeat (2) send_step();
  endtask

  // Steep line toward smaller x and y walked past its end, then a flat one walked to its end.
  task automatic test_full_walks();
    send_item(REQ_START, CB'(10), CB'(20), CB'(8), CB'(14));
    repeat (7) send_step();
    send_item(REQ_START, CB'(CMAX), CB'(5), CB'(CMAX - 3), CB'(5));
    repeat (3) send_step();
  endtask

  task automatic test_random_lines();
    int            kind;
    int            walk;
    int            dx;
    int            dy;
    int            target;
    logic [CB-1:0] sx, sy, ex, ey;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      if ($urandom_range(0, 9) == 0) tx_burst = ~tx_burst;
      if ($urandom_range(0, 9) == 0) rx_burst = ~rx_burst;
      kind = $urandom_range(0, 99);
      if (kind < 92) begin
        sx = CB'($urandom);
        sy = CB'($urandom);
        if (kind < 65) begin
          ex = near_coord(sx, 15);
          ey = near_coord(sy, 15);
        end else if (kind < 80) begin
          sx = edge_coord();
          sy = edge_coord();
          ex = edge_coord();
          ey = edge_coord();
        end else begin
          ex = CB'($urandom);
          ey = CB'($urandom);
        end
        send_item(REQ_START, sx, sy, ex, ey);
        dx   = (ex > sx) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        dy   = (ey > sy) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        walk = (dx > dy) ? dx : dy;
        // long lines are cut short and dropped by the next start
        if (walk > 40)
          walk = $urandom_range(0, 40);
        else if ($urandom_range(0, 9) == 0)
          walk = $urandom_range(0, walk);
        else
          walk += ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        repeat (walk) send_step();
      end else begin
        // noise: unrelated requests of either kind
        send_item(req_type_t'($urandom_range(0, 1)), CB'($urandom), CB'($urandom),
                  CB'($urandom), CB'($urandom));
      end
    end
  endtask

  initial begin
    line_busy = 1'b0;
    walk_x = '0; walk_y = '0; goal_x = '0; goal_y = '0;
    span_x = '0; span_y = '0; neg_x = 1'b0; neg_y = 1'b0;
    walk_err = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_step_without_line();
    test_zero_length_lines();
    test_extreme_endpoints();
    test_full_walks();
    test_random_lines();

    in_valid <= 1'b0;
    // let the predictor see the last accepted item first
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pixel_q.size() != 0) begin
      fail_count++;
      $display("%0t: %0d predicted pixels never arrived", $time, pixel_q.size());
    end
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/lr_pkg.sv
sv/lr_front.sv
sv/lr_queue.sv
sv/lr_back.sv
sv/line_rasterizer_core.sv
sim/tb_line_rasterizer_core.sv
